// File: hw/rtl/gpg_pkg.sv
// ----------------------------------------------------------------------------
// gpg_pkg
// Shared types and constants of the GPIO pattern generator.
// ----------------------------------------------------------------------------
package gpg_pkg;

    // Default width of the microsecond period counter.
    localparam int PeriodCounterBits = 26;

    // Register widths and the configuration port.
    localparam int ModeW      = 3;
    localparam int HzW        = 20;
    localparam int WidthW     = 24;
    localparam int PeriodMsW  = 16;
    localparam int CfgIndexW  = 2;
    localparam int CfgDataW   = 24;

    // Half period of the square wave, and the pulse period in microseconds.
    localparam int HalfW      = 19;
    localparam int ProductW   = 26;
    localparam int UsPerMsW   = 10;

    localparam logic [HalfW-1:0]    HalfSecondUs = HalfW'(500000);
    localparam logic [UsPerMsW-1:0] UsPerMs      = UsPerMsW'(1000);

    // Register indexes on the configuration port.
    localparam logic [CfgIndexW-1:0] CFG_MODE         = 2'd0;
    localparam logic [CfgIndexW-1:0] CFG_SQUARE_HZ    = 2'd1;
    localparam logic [CfgIndexW-1:0] CFG_PULSE_WIDTH  = 2'd2;
    localparam logic [CfgIndexW-1:0] CFG_PULSE_PERIOD = 2'd3;

    // Output modes. Codes five to seven behave as off.
    localparam logic [ModeW-1:0] MODE_OFF    = 3'd0;
    localparam logic [ModeW-1:0] MODE_HIGH   = 3'd1;
    localparam logic [ModeW-1:0] MODE_LOW    = 3'd2;
    localparam logic [ModeW-1:0] MODE_SQUARE = 3'd3;
    localparam logic [ModeW-1:0] MODE_PULSE  = 3'd4;

    // One result item; pin_level sits in the lowest bit when packed.
    typedef struct packed {
        logic config_error;
        logic drive_enable;
        logic pin_level;
    } gpg_status_t;

endpackage

// File: hw/rtl/gpg_div.sv
// ----------------------------------------------------------------------------
// gpg_div
// Restoring divider that works out 500000 / square_hz, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module gpg_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         abort,
    input  logic [gpg_pkg::HzW-1:0]      divisor,
    output logic                         busy,
    output logic                         done,
    output logic [gpg_pkg::HalfW-1:0]    quotient
);

    localparam int CntW = $clog2(gpg_pkg::HalfW);

    logic [CntW-1:0]             cnt_reg,  cnt_next;
    logic                        busy_reg, busy_next;
    logic [gpg_pkg::HzW-1:0]     div_reg,  div_next;
    logic [gpg_pkg::HzW-1:0]     rem_reg,  rem_next;
    logic [gpg_pkg::HalfW-1:0]   quo_reg,  quo_next;

    logic [gpg_pkg::HzW:0]       rem_shift;
    logic [gpg_pkg::HzW:0]       rem_sub;
    logic                        fits;
    logic [gpg_pkg::HalfW-1:0]   quo_step;

    always_comb
    begin
        rem_shift = {rem_reg, gpg_pkg::HalfSecondUs[cnt_reg]};
        rem_sub   = rem_shift - {1'b0, div_reg};
        fits      = (rem_shift >= {1'b0, div_reg});
        quo_step  = {quo_reg[gpg_pkg::HalfW-2:0], fits};
    end

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            cnt_next  = CntW'(gpg_pkg::HalfW - 1);
            busy_next = 1'b1;
            div_next  = divisor;
            rem_next  = '0;
            quo_next  = '0;
        end
        else if (abort)
        begin
            busy_next = 1'b0;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? rem_sub[gpg_pkg::HzW-1:0] : rem_shift[gpg_pkg::HzW-1:0];
            quo_next = quo_step;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign busy     = busy_reg;
    // The final quotient bit is known in the last step; the caller takes it then.
    assign done     = busy_reg && (cnt_reg == '0) && !start && !abort;
    assign quotient = quo_step;

endmodule

// File: hw/rtl/gpg_core.sv
// ----------------------------------------------------------------------------
// gpg_core
// Configuration registers, pattern state and the per-tick update.
// ----------------------------------------------------------------------------
module gpg_core #(
    parameter int PERIOD_COUNTER_BITS = gpg_pkg::PeriodCounterBits
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [gpg_pkg::CfgIndexW-1:0]   cfg_index,
    input  logic [gpg_pkg::CfgDataW-1:0]    cfg_data,
    input  logic                            item_accept,
    input  logic                            tick,
    output logic                            busy,
    output gpg_pkg::gpg_status_t            status_next
);

    localparam int Pw   = PERIOD_COUNTER_BITS;
    localparam int CmpW = (Pw > gpg_pkg::ProductW) ? Pw : gpg_pkg::ProductW;

    // Configuration registers.
    logic [gpg_pkg::ModeW-1:0]      mode_reg,   mode_next;
    logic [gpg_pkg::HzW-1:0]        hz_reg,     hz_next;
    logic [gpg_pkg::WidthW-1:0]     width_reg,  width_next;
    logic [gpg_pkg::PeriodMsW-1:0]  pms_reg,    pms_next;
    logic [Pw-1:0]                  target_reg, target_next;

    // Pattern state.
    logic                           level_reg,   level_next;
    logic                           running_reg, running_next;
    logic [gpg_pkg::HalfW-1:0]      half_reg,    half_next;
    logic [Pw-1:0]                  pcount_reg,  pcount_next;
    logic [gpg_pkg::WidthW-1:0]     wcount_reg,  wcount_next;
    logic                           armed_reg,   armed_next;
    logic                           error_reg,   error_next;

    logic                           div_start;
    logic                           div_busy;
    logic                           div_done;
    logic [gpg_pkg::HalfW-1:0]      div_quo;

    logic [gpg_pkg::ProductW-1:0]   product;
    logic [CmpW-1:0]                product_ext;
    logic [CmpW-1:0]                pmax_ext;
    logic [Pw-1:0]                  pcount_inc;
    logic [gpg_pkg::WidthW-1:0]     wcount_dec;
    logic                           fall_due;

    gpg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .abort    (cfg_we),
        .divisor  (hz_next),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Period target in microseconds, saturated to the counter range.
    always_comb
    begin
        product     = gpg_pkg::ProductW'(pms_next * gpg_pkg::UsPerMs);
        product_ext = CmpW'(product);
        pmax_ext    = CmpW'({Pw{1'b1}});
        target_next = (product_ext > pmax_ext) ? Pw'(pmax_ext) : Pw'(product_ext);
    end

    always_comb
    begin
        mode_next    = mode_reg;
        hz_next      = hz_reg;
        width_next   = width_reg;
        pms_next     = pms_reg;
        level_next   = level_reg;
        running_next = running_reg;
        half_next    = half_reg;
        pcount_next  = pcount_reg;
        wcount_next  = wcount_reg;
        armed_next   = armed_reg;
        error_next   = error_reg;
        div_start    = 1'b0;
        pcount_inc   = pcount_reg + 1'b1;
        wcount_dec   = wcount_reg;
        fall_due     = 1'b0;

        if (cfg_we)
        begin
            unique case (cfg_index)
                gpg_pkg::CFG_MODE:         mode_next  = cfg_data[gpg_pkg::ModeW-1:0];
                gpg_pkg::CFG_SQUARE_HZ:    hz_next    = cfg_data[gpg_pkg::HzW-1:0];
                gpg_pkg::CFG_PULSE_WIDTH:  width_next = cfg_data[gpg_pkg::WidthW-1:0];
                gpg_pkg::CFG_PULSE_PERIOD: pms_next   = cfg_data[gpg_pkg::PeriodMsW-1:0];
                default:                   mode_next  = mode_reg;
            endcase

            // Every write restarts the pattern from a stopped output.
            running_next = 1'b0;
            level_next   = 1'b0;
            pcount_next  = '0;
            wcount_next  = '0;
            armed_next   = 1'b0;
            error_next   = 1'b0;
            if (mode_next == gpg_pkg::MODE_HIGH || mode_next == gpg_pkg::MODE_LOW)
            begin
                running_next = 1'b1;
                level_next   = (mode_next == gpg_pkg::MODE_HIGH);
            end
            else if (mode_next == gpg_pkg::MODE_SQUARE)
            begin
                if (hz_next == '0)
                begin
                    error_next = 1'b1;
                end
                else
                begin
                    running_next = 1'b1;
                    div_start    = 1'b1;
                end
            end
            else if (mode_next == gpg_pkg::MODE_PULSE)
            begin
                if (width_next == '0 || pms_next == '0)
                begin
                    error_next = 1'b1;
                end
                else
                begin
                    running_next = 1'b1;
                end
            end
        end
        else if (item_accept && tick && running_reg)
        begin
            if (mode_reg == gpg_pkg::MODE_SQUARE)
            begin
                pcount_next = pcount_inc;
                if (pcount_inc >= Pw'(half_reg))
                begin
                    pcount_next = '0;
                    level_next  = !level_reg;
                end
            end
            else if (mode_reg == gpg_pkg::MODE_PULSE)
            begin
                if (armed_reg)
                begin
                    if (wcount_reg != '0)
                    begin
                        wcount_dec = wcount_reg - 1'b1;
                    end
                    fall_due = (wcount_dec == '0);
                end
                wcount_next = wcount_dec;
                pcount_next = pcount_inc;
                // A rise in the same tick as a fall wins and re-arms the fall.
                if (pcount_inc >= target_reg)
                begin
                    pcount_next = '0;
                    level_next  = 1'b1;
                    armed_next  = 1'b1;
                    wcount_next = width_reg;
                end
                else if (fall_due)
                begin
                    level_next = 1'b0;
                    armed_next = 1'b0;
                end
            end
        end

        if (div_done)
        begin
            half_next = (div_quo == '0) ? gpg_pkg::HalfW'(1) : div_quo;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= gpg_pkg::MODE_OFF;
            hz_reg      <= '0;
            width_reg   <= '0;
            pms_reg     <= '0;
            target_reg  <= '0;
            level_reg   <= 1'b0;
            running_reg <= 1'b0;
            half_reg    <= gpg_pkg::HalfW'(1);
            pcount_reg  <= '0;
            wcount_reg  <= '0;
            armed_reg   <= 1'b0;
            error_reg   <= 1'b0;
        end
        else
        begin
            mode_reg    <= mode_next;
            hz_reg      <= hz_next;
            width_reg   <= width_next;
            pms_reg     <= pms_next;
            target_reg  <= target_next;
            level_reg   <= level_next;
            running_reg <= running_next;
            half_reg    <= half_next;
            pcount_reg  <= pcount_next;
            wcount_reg  <= wcount_next;
            armed_reg   <= armed_next;
            error_reg   <= error_next;
        end
    end

    assign busy = div_busy;

    always_comb
    begin
        status_next.pin_level    = running_next && level_next;
        status_next.drive_enable = running_next;
        status_next.config_error = error_next;
    end

endmodule

// File: hw/rtl/gpio_pattern_generator.sv
// ----------------------------------------------------------------------------
// gpio_pattern_generator
// Square wave, periodic pulse and static high or low generator for one pin, stepped by us ticks.
//
//   Channel   Direction  Payload
//   s_axis    in         tdata[0] tick
//   m_axis    out        tdata[0] pin_level, [1] drive_enable, [2] config_error
//   cfg       in         cfg_we, cfg_index, cfg_data (no read-back)
//
// Each tick item gives one result item, registered and shown on m_axis in the cycle after it is
// accepted; one item per cycle while s_tready is high. A configuration write that selects the
// square wave starts a divider; s_tready stays low until the half period is known.
// A result waiting on m_axis does not block a new tick while m_tready is high.
// Reset puts the core in the released state with no error; the result register is not reset.
// ----------------------------------------------------------------------------
module gpio_pattern_generator #(
    parameter int PERIOD_COUNTER_BITS = gpg_pkg::PeriodCounterBits
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [0] tick
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,   // [0] pin_level, [1] drive_enable,
                                                       // [2] config_error
    input  logic                            cfg_we,
    input  logic [gpg_pkg::CfgIndexW-1:0]   cfg_index,
    input  logic [gpg_pkg::CfgDataW-1:0]    cfg_data
);

    logic                   busy;
    logic                   item_accept;
    gpg_pkg::gpg_status_t   status_next;
    gpg_pkg::gpg_status_t   result_reg;
    logic                   out_valid_reg, out_valid_next;

    gpg_core #(
        .PERIOD_COUNTER_BITS (PERIOD_COUNTER_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .item_accept (item_accept),
        .tick        (s_tdata[0]),
        .busy        (busy),
        .status_next (status_next)
    );

    assign s_tready    = !busy && !cfg_we && (!out_valid_reg || m_tready);
    assign item_accept = s_tvalid && s_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (item_accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            result_reg <= status_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, result_reg};

endmodule
